// ===== rtl/eau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_pkg: shared types and constants of the elementwise activation unit
// Holds data widths, register indexes, the function mode codes and the
// sigmoid node table, which is built at elaboration.
// ----------------------------------------------------------------------------
package eau_pkg;

   // Data path widths
   localparam int DATA_W  = 16;                 // signed Q4.12 word
   localparam int MAG_W   = DATA_W + 1;         // |x| up to 32768
   localparam int FRAC_W  = 15;                 // interpolation fraction
   localparam int SIG_W   = 13;                 // sigmoid value 0..4096
   localparam int LEAK_W  = 12;                 // slope, unsigned Q0.12
   localparam int LPROD_W = MAG_W + LEAK_W;     // |x| * slope
   localparam int LQ_W    = MAG_W;              // rounded leaky magnitude

   // Sigmoid node table
   localparam int SIG_TABLE_DEPTH = 256;
   localparam int IDX_W  = $clog2(SIG_TABLE_DEPTH + 1);
   localparam int PROD_W = FRAC_W + IDX_W;      // |x| * depth
   localparam int IPROD_W = SIG_W + FRAC_W;     // slope * fraction
   localparam int DPROD_W = 2 * SIG_W;          // s * (1 - s)

   localparam logic [SIG_W-1:0]  SIG_ONE   = SIG_W'(4096);
   localparam logic [DATA_W-1:0] Q12_ONE   = DATA_W'(4096);
   localparam logic [IPROD_W:0]  INTERP_RND = (IPROD_W + 1)'(16384);
   localparam logic [LPROD_W-1:0] LEAK_RND = LPROD_W'(4095);

   // Configuration registers
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LEAK_W;
   localparam logic [CSR_IDX_W-1:0] CSR_FUNC_MODE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_SEL  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK_SLOPE = CSR_IDX_W'(2);
   localparam logic [LEAK_W-1:0]    LEAK_RESET     = LEAK_W'(41);

   typedef enum logic [1:0] {
      MODE_RELU    = 2'd0,
      MODE_LEAKY   = 2'd1,
      MODE_SIGMOID = 2'd2
   } func_mode_type;

   typedef logic [SIG_W-1:0] sig_rom_type [0:SIG_TABLE_DEPTH];

   // Floor quotient of two non-negative values by shift and subtract
   function automatic longint const_udiv(input longint num, input longint den);
      longint quo;
      longint rem;
      int b;
      quo = 0;
      rem = 0;
      for (b = 62; b >= 0; b--) begin
         rem = (rem <<< 1) | ((num >>> b) & longint'(1));
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (longint'(1) <<< b);
         end
      end
      return quo;
   endfunction

   // Node k holds round(4096 / (1 + e^(-8k/depth))): e^(-k/depth) from a
   // truncating Taylor series in Q30, raised to the eighth power by squaring.
   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      longint g;
      longint term;
      longint sum;
      longint a;
      longint d;
      int k;
      int n;
      int i;
      for (k = 0; k <= SIG_TABLE_DEPTH; k++) begin
         g    = (longint'(k) <<< 30) / SIG_TABLE_DEPTH;
         term = longint'(1) <<< 30;
         sum  = longint'(1) <<< 30;
         for (n = 1; n <= 20; n++) begin
            term = (term * g) >>> 30;
            term = const_udiv(term, longint'(n));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         a = sum;
         for (i = 0; i < 3; i++) begin
            a = (a * a) >>> 30;
         end
         d = (longint'(1) <<< 30) + a;
         rom[k] = SIG_W'(const_udiv((longint'(4096) <<< 30) + (d >>> 1), d));
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

endpackage

// ===== rtl/eau_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_req_if / eau_rsp_if: word channels of the activation unit
// Valid/ready handshake; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface eau_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [eau_pkg::DATA_W-1:0]  x_value;

   modport source (output valid, output x_value, input ready);
   modport sink   (input valid, input x_value, output ready);
endinterface

interface eau_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [eau_pkg::DATA_W-1:0]  y_value;

   modport source (output valid, output y_value, input ready);
   modport sink   (input valid, input y_value, output ready);
endinterface

// ===== rtl/eau_sig_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eau_sig_lookup: sigmoid node pair read
// Reads the node at the segment index and the rise to the next node; past
// the last segment the curve is flat at the last node.
// ----------------------------------------------------------------------------
module eau_sig_lookup (
   input  logic [eau_pkg::IDX_W-1:0] seg_idx,
   output logic [eau_pkg::SIG_W-1:0] node_lo,
   output logic [eau_pkg::SIG_W-1:0] node_rise
);
   import eau_pkg::*;

   logic                 last_seg;
   logic [IDX_W-1:0]     next_idx;
   logic [SIG_W-1:0]     lo_val;
   logic [SIG_W-1:0]     hi_val;

   // Pick the node pair, clamping at the end of the table
   always_comb begin
      last_seg = (seg_idx >= IDX_W'(SIG_TABLE_DEPTH));
      next_idx = last_seg ? seg_idx : seg_idx + IDX_W'(1);
      lo_val   = last_seg ? SIG_ROM[SIG_TABLE_DEPTH] : SIG_ROM[seg_idx];
      hi_val   = SIG_ROM[next_idx];
   end

   // Form the rise, never negative
   always_comb begin
      node_lo   = lo_val;
      node_rise = (!last_seg && hi_val >= lo_val) ? hi_val - lo_val : '0;
   end

endmodule

// ===== rtl/elementwise_activation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elementwise_activation_unit: ReLU / leaky ReLU / sigmoid and derivatives
// Four-stage pipeline over signed Q4.12 words.
// ----------------------------------------------------------------------------
// Use:
//   req carries one signed Q4.12 word x_value per handshake; rsp returns one
//   signed Q4.12 word y_value for each, in order. csr_wen/csr_index/csr_wdata
//   write func_mode (0 ReLU, 1 leaky ReLU, 2 sigmoid, 3 gives zero),
//   derivative_sel and leak_slope (Q0.12); write them only while the
//   pipeline is empty.
// Stages and throughput:
//   An accepted word passes through four registered stages in order
//   (magnitude/scale, node read and leaky rounding, interpolation multiply,
//   derivative multiply and select) before it shows on rsp.
//   One word per cycle is sustained while rsp.ready stays high.
// Reset:
//   Synchronous, active high. Empties the pipeline and loads func_mode 0,
//   derivative_sel 0 and leak_slope 41.
// Stall:
//   When rsp.ready is low the output word holds; upstream stages keep
//   filling until full, so req.ready drops only when all four are occupied.
// ----------------------------------------------------------------------------
module elementwise_activation_unit (
   input  logic                            clock,
   input  logic                            reset,
   eau_req_if.sink                         req,
   eau_rsp_if.source                       rsp,
   input  logic                            csr_wen,
   input  logic [eau_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [eau_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import eau_pkg::*;

   // Configuration registers
   func_mode_type        func_mode_ff;
   logic                 deriv_sel_ff;
   logic [LEAK_W-1:0]    leak_slope_ff;

   // Stage valids and enables
   logic                 vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic                 en1, en2, en3, en4;

   // Stage 1
   logic [MAG_W-1:0]     mag_in;
   logic [PROD_W-1:0]    scaled_in;
   logic [DATA_W-1:0]    x1_ff;
   logic [IDX_W-1:0]     seg1_ff;
   logic [FRAC_W-1:0]    frac1_ff;
   logic [LPROD_W-1:0]   lprod1_ff;

   // Stage 2
   logic                 pos1;
   logic [LQ_W-1:0]      leak_q;
   logic [DATA_W-1:0]    direct2_in;
   logic [SIG_W-1:0]     lo2_in;
   logic [SIG_W-1:0]     rise2_in;
   logic [DATA_W-1:0]    direct2_ff;
   logic [SIG_W-1:0]     lo2_ff;
   logic [SIG_W-1:0]     rise2_ff;
   logic [FRAC_W-1:0]    frac2_ff;
   logic                 neg2_ff;

   // Stage 3
   logic [IPROD_W:0]     interp;
   logic [SIG_W:0]       s_sum;
   logic [SIG_W-1:0]     s_mag;
   logic [SIG_W-1:0]     s3_in;
   logic [SIG_W-1:0]     s3_ff;
   logic [DATA_W-1:0]    direct3_ff;

   // Stage 4
   logic [DPROD_W-1:0]   dprod;
   logic [DATA_W-1:0]    y4_in;
   logic [DATA_W-1:0]    y4_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         func_mode_ff  <= MODE_RELU;
         deriv_sel_ff  <= 1'b0;
         leak_slope_ff <= LEAK_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_FUNC_MODE:  func_mode_ff  <= func_mode_type'(csr_wdata[1:0]);
            CSR_DERIV_SEL:  deriv_sel_ff  <= csr_wdata[0];
            CSR_LEAK_SLOPE: leak_slope_ff <= csr_wdata[LEAK_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance a stage when it is empty or the next one advances
   always_comb begin
      en4 = !vld4_ff || rsp.ready;
      en3 = !vld3_ff || en4;
      en2 = !vld2_ff || en3;
      en1 = !vld1_ff || en2;
   end

   assign req.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (en1) vld1_ff <= req.valid;
         if (en2) vld2_ff <= vld1_ff;
         if (en3) vld3_ff <= vld2_ff;
         if (en4) vld4_ff <= vld3_ff;
      end
   end

   // Stage 1: magnitude, table position and leaky product
   always_comb begin
      mag_in    = req.x_value[DATA_W-1] ? MAG_W'(~{req.x_value[DATA_W-1], req.x_value} + 1'b1)
                                        : MAG_W'({1'b0, req.x_value});
      scaled_in = PROD_W'(mag_in) * PROD_W'(SIG_TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (en1 && req.valid) begin
         x1_ff     <= req.x_value;
         seg1_ff   <= scaled_in[FRAC_W +: IDX_W];
         frac1_ff  <= scaled_in[FRAC_W-1:0];
         lprod1_ff <= LPROD_W'(mag_in) * LPROD_W'(leak_slope_ff);
      end
   end

   // Stage 2: node read and the piecewise-linear modes
   eau_sig_lookup u_sig_lookup (
      .seg_idx   (seg1_ff),
      .node_lo   (lo2_in),
      .node_rise (rise2_in)
   );

   always_comb begin
      pos1   = !x1_ff[DATA_W-1] && (x1_ff != '0);
      leak_q = LQ_W'((lprod1_ff + LEAK_RND) >> LEAK_W);
      case (func_mode_ff)
         MODE_RELU: begin
            if (deriv_sel_ff) direct2_in = pos1 ? Q12_ONE : '0;
            else              direct2_in = pos1 ? x1_ff : '0;
         end
         MODE_LEAKY: begin
            if (deriv_sel_ff) direct2_in = pos1 ? Q12_ONE : DATA_W'(leak_slope_ff);
            else if (pos1)    direct2_in = x1_ff;
            else              direct2_in = DATA_W'(~leak_q + 1'b1);
         end
         default:             direct2_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en2 && vld1_ff) begin
         direct2_ff <= direct2_in;
         lo2_ff     <= lo2_in;
         rise2_ff   <= rise2_in;
         frac2_ff   <= frac1_ff;
         neg2_ff    <= x1_ff[DATA_W-1];
      end
   end

   // Stage 3: interpolate, clamp and fold for negative inputs
   always_comb begin
      interp = (IPROD_W + 1)'(IPROD_W'(rise2_ff) * IPROD_W'(frac2_ff)) + INTERP_RND;
      s_sum  = (SIG_W + 1)'(lo2_ff) + (SIG_W + 1)'(interp >> FRAC_W);
      s_mag  = (s_sum > (SIG_W + 1)'(SIG_ONE)) ? SIG_ONE : s_sum[SIG_W-1:0];
      s3_in  = neg2_ff ? SIG_ONE - s_mag : s_mag;
   end

   always_ff @(posedge clock) begin
      if (en3 && vld2_ff) begin
         s3_ff      <= s3_in;
         direct3_ff <= direct2_ff;
      end
   end

   // Stage 4: sigmoid derivative and final select
   always_comb begin
      dprod = DPROD_W'(s3_ff) * DPROD_W'(SIG_ONE - s3_ff);
      if (func_mode_ff == MODE_SIGMOID) begin
         y4_in = deriv_sel_ff ? DATA_W'(dprod >> 12) : DATA_W'(s3_ff);
      end else begin
         y4_in = direct3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4 && vld3_ff) begin
         y4_ff <= y4_in;
      end
   end

   assign rsp.valid   = vld4_ff;
   assign rsp.y_value = y4_ff;

   // Occupancy follows accepted and delivered words
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones({vld1_ff, vld2_ff, vld3_ff, vld4_ff}) ==
               $past($countones({vld1_ff, vld2_ff, vld3_ff, vld4_ff}))
               + int'($past(req.valid && req.ready)) - int'($past(rsp.valid && rsp.ready)))
      else $error("pipeline occupancy does not match handshakes");

   // A stalled stage 2 keeps its word
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      vld2_ff && !en3 |=> vld2_ff && $stable(lo2_ff) && $stable(rise2_ff)
                          && $stable(direct2_ff) && $stable(frac2_ff))
      else $error("stage 2 word changed while stalled");

   // Sigmoid value never exceeds one
   a_sig_range: assert property (@(posedge clock) disable iff (reset)
      vld3_ff |-> s3_ff <= SIG_ONE)
      else $error("sigmoid value out of range");

   // An empty first stage always takes a word
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !vld1_ff |-> req.ready)
      else $error("input not ready with an empty first stage");

endmodule
